@@ hw/rtl/jds_pkg.sv @@
// ----------------------------------------------------------------------------
// jds_pkg
// Shared types and constants for the job duration sorter.
// ----------------------------------------------------------------------------
package jds_pkg;

  localparam int unsigned DUR_W  = 32;
  localparam int unsigned MODE_W = 2;

  // ordering modes, any other code keeps arrival order
  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC = 2'd2;

  typedef struct packed {
    logic load;       // input word accepted
    logic clr_batch;  // batch finished, clear count and flags
    logic rd_i;       // read entry i, start of a selection pass
    logic scan_rd;    // read entry j during a selection pass
    logic swap_a;     // write entry i value into the best slot
    logic swap_b;     // write best value into slot i, advance i
    logic emit_rd;    // read entry k for output
    logic emit_cap;   // capture read data into output register
  } jds_cmd_t;

  typedef struct packed {
    logic sort_needed;
    logic scan_done;
    logic sort_done;
    logic out_taken;
    logic emit_last;
  } jds_sts_t;

endpackage

@@ hw/rtl/jds_in_if.sv @@
// ----------------------------------------------------------------------------
// jds_in_if
// Input channel: one job duration per word, with end of batch marker.
// ----------------------------------------------------------------------------
interface jds_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [jds_pkg::DUR_W-1:0] duration;
  logic                            last_job;

  modport source (output valid, output duration, output last_job, input ready);
  modport sink   (input valid, input duration, input last_job, output ready);
endinterface

@@ hw/rtl/jds_out_if.sv @@
// ----------------------------------------------------------------------------
// jds_out_if
// Result channel: durations in scheduled order.
// ----------------------------------------------------------------------------
interface jds_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [jds_pkg::DUR_W-1:0] sorted_duration;
  logic                            last_out;
  logic                            dropped;

  modport source (output valid, output sorted_duration, output last_out,
                  output dropped, input ready);
  modport sink   (input valid, input sorted_duration, input last_out,
                  input dropped, output ready);
endinterface

@@ hw/rtl/jds_cfg_if.sv @@
// ----------------------------------------------------------------------------
// jds_cfg_if
// Configuration write channel for the ordering mode register.
// ----------------------------------------------------------------------------
interface jds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [jds_pkg::MODE_W-1:0] order_mode;

  modport source (output valid, output order_mode, input ready);
  modport sink   (input valid, input order_mode, output ready);
endinterface

@@ hw/rtl/job_duration_sorter.sv @@
// ----------------------------------------------------------------------------
// job_duration_sorter
// Collects a batch of signed durations and emits them in arrival,
// ascending or descending order using selection sort over a single RAM.
// ----------------------------------------------------------------------------
// sorting: one selection pass for each slot but the last, each pass scanning
//   through the single read port of the job store (one compare per cycle)
// emission: each result is read, captured and held until the sink takes it
// a new batch is accepted only after the last result has been taken
// reset: synchronous rst_n clears count, overflow flag, mode and sequencer;
//   store contents are not cleared
module job_duration_sorter #(
  parameter int unsigned MAX_JOBS = 64
) (
  input  logic    clk,
  input  logic    rst_n,
  jds_in_if.sink  in_if,
  jds_out_if.source out_if,
  jds_cfg_if.sink cfg_if
);

  jds_pkg::jds_cmd_t cmd;
  jds_pkg::jds_sts_t sts;

  assign cfg_if.ready = 1'b1;

  jds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.last_job),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jds_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_duration    (in_if.duration),
    .cfg_valid      (cfg_if.valid),
    .cfg_order_mode (cfg_if.order_mode),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_duration   (out_if.sorted_duration),
    .out_last       (out_if.last_out),
    .out_dropped    (out_if.dropped)
  );

endmodule

@@ hw/rtl/jds_ram.sv @@
// ----------------------------------------------------------------------------
// jds_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module jds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hw/rtl/jds_ctrl.sv @@
// ----------------------------------------------------------------------------
// jds_ctrl
// Sequencer: batch load, selection sort passes and result emission.
// ----------------------------------------------------------------------------
module jds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  jds_pkg::jds_sts_t sts,
  output jds_pkg::jds_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_DECIDE,
    S_RD_I,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_EMIT_RD,
    S_EMIT_CAP,
    S_EMIT_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load = accept;
        if (accept && in_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = sts.sort_needed ? S_RD_I : S_EMIT_RD;
      end
      S_RD_I: begin
        cmd.rd_i  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // last compare lands on the edge that leaves this state, while the scan index equals the count
        if (sts.scan_done) begin
          state_nxt = S_SWAP_A;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_SWAP_A: begin
        cmd.swap_a = 1'b1;
        state_nxt  = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.swap_b = 1'b1;
        state_nxt  = sts.sort_done ? S_EMIT_RD : S_RD_I;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_CAP;
      end
      S_EMIT_CAP: begin
        cmd.emit_cap = 1'b1;
        state_nxt    = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_taken) begin
          if (sts.emit_last) begin
            cmd.clr_batch = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/jds_dp.sv @@
// ----------------------------------------------------------------------------
// jds_dp
// Datapath: job store, counters, min/max tracking and output register.
// ----------------------------------------------------------------------------
module jds_dp #(
  parameter int unsigned MAX_JOBS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  jds_pkg::jds_cmd_t                cmd,
  output jds_pkg::jds_sts_t                sts,
  input  logic signed [jds_pkg::DUR_W-1:0] in_duration,
  input  logic                             cfg_valid,
  input  logic [jds_pkg::MODE_W-1:0]       cfg_order_mode,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [jds_pkg::DUR_W-1:0] out_duration,
  output logic                             out_last,
  output logic                             out_dropped
);

  localparam int unsigned AW = $clog2(MAX_JOBS);
  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_I,
    TAG_J
  } tag_t;

  logic [CW-1:0]                    cnt_r;
  logic                             ovf_r;
  logic [jds_pkg::MODE_W-1:0]       mode_r;
  logic [AW-1:0]                    i_r;
  logic [CW-1:0]                    j_r;
  logic [AW-1:0]                    k_r;
  tag_t                             tag_r;
  logic [AW-1:0]                    tag_idx_r;
  logic signed [jds_pkg::DUR_W-1:0] ival_r;
  logic signed [jds_pkg::DUR_W-1:0] best_val_r;
  logic [AW-1:0]                    best_idx_r;
  logic                             out_valid_r;
  logic signed [jds_pkg::DUR_W-1:0] out_dur_r;
  logic                             out_last_r;
  logic                             out_drop_r;

  logic                             full;
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic [jds_pkg::DUR_W-1:0]        ram_wdata;
  logic                             ram_re;
  logic [AW-1:0]                    ram_raddr;
  logic [jds_pkg::DUR_W-1:0]        ram_rdata;
  logic signed [jds_pkg::DUR_W-1:0] rd_val;
  logic                             asc;
  logic                             better;
  logic                             out_taken;

  assign full      = (cnt_r == CW'(MAX_JOBS));
  assign rd_val    = $signed(ram_rdata);
  assign asc       = (mode_r == jds_pkg::MODE_ASC);
  assign better    = asc ? (rd_val < best_val_r) : (rd_val > best_val_r);
  assign out_taken = out_valid_r && out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = in_duration;
    if (cmd.load && !full) begin
      ram_we = 1'b1;
    end else if (cmd.swap_a) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
      ram_wdata = ival_r;
    end else if (cmd.swap_b) begin
      ram_we    = 1'b1;
      ram_waddr = i_r;
      ram_wdata = best_val_r;
    end
  end

  assign ram_re    = cmd.rd_i || cmd.scan_rd || cmd.emit_rd;
  assign ram_raddr = cmd.rd_i ? i_r : (cmd.scan_rd ? j_r[AW-1:0] : k_r);

  jds_ram #(
    .WIDTH (jds_pkg::DUR_W),
    .DEPTH (MAX_JOBS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      mode_r      <= jds_pkg::MODE_FCFS;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      tag_r       <= TAG_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_order_mode;
      end
      if (cmd.load) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.rd_i) begin
        j_r <= CW'(i_r) + CW'(1);
      end else if (cmd.scan_rd) begin
        j_r <= j_r + CW'(1);
      end
      if (cmd.swap_b) begin
        i_r <= i_r + AW'(1);
      end
      if (cmd.rd_i) begin
        tag_r <= TAG_I;
      end else if (cmd.scan_rd) begin
        tag_r <= TAG_J;
      end else begin
        tag_r <= TAG_NONE;
      end
      if (cmd.emit_cap) begin
        out_valid_r <= 1'b1;
      end else if (out_taken) begin
        out_valid_r <= 1'b0;
        k_r         <= k_r + AW'(1);
      end
      if (cmd.clr_batch) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
        i_r   <= '0;
        k_r   <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    tag_idx_r <= ram_raddr;
    case (tag_r)
      TAG_I: begin
        ival_r     <= rd_val;
        best_val_r <= rd_val;
        best_idx_r <= tag_idx_r;
      end
      TAG_J: begin
        // strict compare keeps the first candidate on ties
        if (better) begin
          best_val_r <= rd_val;
          best_idx_r <= tag_idx_r;
        end
      end
      default: begin
      end
    endcase
    if (cmd.emit_cap) begin
      out_dur_r  <= rd_val;
      out_last_r <= ((SW'(k_r) + SW'(1)) == SW'(cnt_r));
      out_drop_r <= ovf_r;
    end
  end

  assign sts.sort_needed = ((mode_r == jds_pkg::MODE_ASC) || (mode_r == jds_pkg::MODE_DESC))
                           && (cnt_r >= CW'(2));
  assign sts.scan_done   = (j_r == cnt_r);
  assign sts.sort_done   = ((SW'(i_r) + SW'(2)) >= SW'(cnt_r));
  assign sts.out_taken   = out_taken;
  assign sts.emit_last   = out_last_r;

  assign out_valid    = out_valid_r;
  assign out_duration = out_dur_r;
  assign out_last     = out_last_r;
  assign out_dropped  = out_drop_r;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_JOBS))
    else $error("job count beyond store capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> (j_r < cnt_r))
    else $error("scan read beyond stored jobs");

  a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ((SW'(k_r) + SW'(1)) == SW'(cnt_r)))
    else $error("last flag on wrong result");

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_b |-> $past(cmd.swap_a))
    else $error("second swap write without first");
`endif

endmodule
